@@ rtl/core/mdhls_pkg.sv @@
// Shared constants, codes and byte classifiers for the heading line scanner.
package mdhls_pkg;

	localparam int unsigned LINE_INDEX_BITS = 16;
	localparam int unsigned LINE_OUT_BITS   = 16;
	localparam int unsigned LEVEL_BITS      = 3;
	localparam int unsigned PHASE_BITS      = 3;
	localparam int unsigned RUN_BITS        = 3;

	typedef logic [LINE_INDEX_BITS-1:0] line_cnt_t;
	typedef logic [PHASE_BITS-1:0]      phase_t;
	typedef logic [RUN_BITS-1:0]        run_t;
	typedef logic [LEVEL_BITS-1:0]      level_t;

	localparam line_cnt_t LINE_CNT_MAX = '1;

	localparam phase_t PH_START = 3'd0;
	localparam phase_t PH_WS    = 3'd1;
	localparam phase_t PH_FENCE = 3'd2;
	localparam phase_t PH_HASH  = 3'd3;
	localparam phase_t PH_DEAD  = 3'd4;

	localparam logic [7:0] CH_NEWLINE  = 8'h0A;
	localparam logic [7:0] CH_HASH     = 8'h23;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_BACKTICK = 8'h60;
	localparam logic [7:0] CH_TILDE    = 8'h7E;

	localparam run_t WS_RUN_MAX    = 3'd3;
	localparam run_t FENCE_RUN_MIN = 3'd3;
	localparam run_t HASH_RUN_MAX  = 3'd6;

	function automatic logic is_ws(input logic [7:0] b);
		is_ws = b inside {8'h09, 8'h0B, 8'h0C, 8'h0D, CH_SPACE};
	endfunction

	function automatic logic is_marker(input logic [7:0] b);
		is_marker = (b == CH_BACKTICK) || (b == CH_TILDE);
	endfunction

endpackage

@@ rtl/core/markdown_heading_line_scanner.sv @@
// Heading line scanner: byte-per-cycle heading and code-fence tracker with registered I/O.
//
// Takes one document byte per clock unless text_stall is high, and emits one beat for
// each heading found outside fenced code (line index and level 1..6), plus a final beat
// with document_done set on the end_of_text item. Bytes pass the input register and
// results the result register; the line phase, run length and fence registers update
// on each accepted byte. The line counter saturates at 2**16-1, and state returns to
// reset after each end_of_text item, so documents may follow back to back.
module markdown_heading_line_scanner
	import mdhls_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     text_valid,
	output logic                     text_stall,
	input  logic [7:0]               text_byte,
	input  logic                     byte_present,
	input  logic                     end_of_text,
	output logic                     heading_valid,
	input  logic                     heading_stall,
	output logic [LINE_OUT_BITS-1:0] line_number,
	output logic [LEVEL_BITS-1:0]    heading_level,
	output logic                     document_done
);

	// input register
	logic       vld_s1;
	logic [7:0] byte_s1;
	logic       present_s1;
	logic       last_s1;

	// scanner state
	logic      inside_fence_q;
	logic      fence_is_tilde_q;
	phase_t    phase_q;
	run_t      run_q;
	logic      run_is_tilde_q;
	line_cnt_t line_cnt_q;

	// result register
	logic                     vld_s2;
	logic [LINE_OUT_BITS-1:0] line_s2;
	level_t                   level_s2;
	logic                     done_s2;

	logic      inside_fence_d;
	logic      fence_is_tilde_d;
	phase_t    phase_d;
	run_t      run_d;
	logic      run_is_tilde_d;
	line_cnt_t line_cnt_d;
	level_t    level_byte;
	level_t    level_d;
	logic      has_result;
	logic      out_free;
	logic      adv;
	logic      take;

	always_comb begin
		inside_fence_d   = inside_fence_q;
		fence_is_tilde_d = fence_is_tilde_q;
		phase_d          = phase_q;
		run_d            = run_q;
		run_is_tilde_d   = run_is_tilde_q;
		line_cnt_d       = line_cnt_q;
		level_byte       = '0;
		if (present_s1) begin
			if (byte_s1 == CH_NEWLINE) begin
				if (phase_q == PH_HASH)
					level_byte = run_q;
				phase_d = PH_START;
				run_d   = '0;
				if (line_cnt_q != LINE_CNT_MAX)
					line_cnt_d = line_cnt_q + 1'b1;
			end else begin
				case (phase_q)
					PH_START: begin
						if (is_ws(byte_s1)) begin
							phase_d = PH_WS;
							run_d   = 3'd1;
						end else if (is_marker(byte_s1)) begin
							phase_d        = PH_FENCE;
							run_d          = 3'd1;
							run_is_tilde_d = (byte_s1 == CH_TILDE);
						end else if (byte_s1 == CH_HASH && !inside_fence_q) begin
							phase_d = PH_HASH;
							run_d   = 3'd1;
						end else begin
							phase_d = PH_DEAD;
						end
					end
					PH_WS: begin
						if (is_ws(byte_s1)) begin
							if (run_q < WS_RUN_MAX)
								run_d = run_q + 3'd1;
							else
								phase_d = PH_DEAD;
						end else if (is_marker(byte_s1)) begin
							phase_d        = PH_FENCE;
							run_d          = 3'd1;
							run_is_tilde_d = (byte_s1 == CH_TILDE);
						end else begin
							phase_d = PH_DEAD;
						end
					end
					PH_FENCE: begin
						if (is_marker(byte_s1) && ((byte_s1 == CH_TILDE) == run_is_tilde_q)) begin
							run_d = run_q + 3'd1;
							if (run_d >= FENCE_RUN_MIN) begin
								if (!inside_fence_q) begin
									inside_fence_d   = 1'b1;
									fence_is_tilde_d = run_is_tilde_q;
								end else if (fence_is_tilde_q == run_is_tilde_q) begin
									inside_fence_d = 1'b0;
								end
								phase_d = PH_DEAD;
							end
						end else begin
							phase_d = PH_DEAD;
						end
					end
					PH_HASH: begin
						if (byte_s1 == CH_HASH) begin
							if (run_q < HASH_RUN_MAX)
								run_d = run_q + 3'd1;
							else
								phase_d = PH_DEAD;
						end else if (byte_s1 == CH_SPACE) begin
							level_byte = run_q;
							phase_d    = PH_DEAD;
						end else begin
							phase_d = PH_DEAD;
						end
					end
					default: begin
						phase_d = PH_DEAD;
					end
				endcase
			end
		end
		level_d = level_byte;
		if (level_byte == '0 && last_s1 && phase_d == PH_HASH)
			level_d = run_d;
		has_result = (level_d != '0) || last_s1;
	end

	assign out_free   = !vld_s2 || !heading_stall;
	assign adv        = vld_s1 && (!has_result || out_free);
	assign text_stall = vld_s1 && !adv;
	assign take       = text_valid && !text_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1    <= text_byte;
			present_s1 <= byte_present;
			last_s1    <= end_of_text;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_fence_q   <= 1'b0;
			fence_is_tilde_q <= 1'b0;
			phase_q          <= PH_START;
			run_q            <= '0;
			run_is_tilde_q   <= 1'b0;
			line_cnt_q       <= '0;
		end else if (adv) begin
			if (last_s1) begin
				inside_fence_q   <= 1'b0;
				fence_is_tilde_q <= 1'b0;
				phase_q          <= PH_START;
				run_q            <= '0;
				run_is_tilde_q   <= 1'b0;
				line_cnt_q       <= '0;
			end else begin
				inside_fence_q   <= inside_fence_d;
				fence_is_tilde_q <= fence_is_tilde_d;
				phase_q          <= phase_d;
				run_q            <= run_d;
				run_is_tilde_q   <= run_is_tilde_d;
				line_cnt_q       <= line_cnt_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv && has_result) begin
			vld_s2 <= 1'b1;
		end else if (!heading_stall) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && has_result) begin
			line_s2  <= (level_d != '0) ? LINE_OUT_BITS'(line_cnt_q) : '0;
			level_s2 <= level_d;
			done_s2  <= last_s1;
		end
	end

	assign heading_valid = vld_s2;
	assign line_number   = line_s2;
	assign heading_level = level_s2;
	assign document_done = done_s2;

`ifndef SYNTHESIS
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		heading_valid && !document_done |-> heading_level != '0 && heading_level <= 3'd6)
		else $error("heading beat with level out of range");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		text_stall |-> vld_s1 && vld_s2 && heading_stall)
		else $error("input stalled with no blocked result");

	a_doc_reset: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> line_cnt_q == '0 && !inside_fence_q && phase_q == PH_START)
		else $error("state not cleared after end of text");

	a_done_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> heading_valid && document_done)
		else $error("end of text gave no final beat");
`endif

endmodule
